>>> hdl/assert_macros.svh
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/ted_pkg.sv
// Shared types, constants and functions of the token edit distance block.
package ted_pkg;

	localparam int TOKEN_W = 16;
	localparam int DIST_W = 16;
	localparam int REQ_W = 2;
	localparam int MAX_REF_LEN_DEF = 64;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// Request codes on the input channel.
	localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
	localparam logic [REQ_W-1:0] REQ_HYP = 2'd1;
	localparam logic [REQ_W-1:0] REQ_END = 2'd2;

	// Operation carried by the wavefront through the cell chain.
	typedef enum logic [1:0] {
		OP_NOP,
		OP_APPEND,
		OP_HYP,
		OP_END
	} op_t;

	typedef struct packed {
		op_t op;
		logic [TOKEN_W-1:0] token;
		logic [DIST_W-1:0] left;
		logic [DIST_W-1:0] diag;
		logic [DIST_W-1:0] result;
		logic ovf;
	} wave_t;

	function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
		return (v == DIST_MAX) ? v : v + DIST_W'(1);
	endfunction

endpackage

>>> hdl/ted_req_if.sv
// Request channel of the token edit distance block.
interface ted_req_if;
	logic valid;
	logic ready;
	logic [ted_pkg::REQ_W-1:0] req_type;
	logic [ted_pkg::TOKEN_W-1:0] token;
	logic first_of_ref;

	modport source(output valid, req_type, token, first_of_ref, input ready);
	modport sink(input valid, req_type, token, first_of_ref, output ready);
endinterface

>>> hdl/ted_res_if.sv
// Result channel of the token edit distance block.
interface ted_res_if;
	logic valid;
	logic ready;
	logic [ted_pkg::DIST_W-1:0] distance;
	logic ref_overflow;

	modport source(output valid, distance, ref_overflow, input ready);
	modport sink(input valid, distance, ref_overflow, output ready);
endinterface

>>> hdl/ted_head.sv
// Head of the chain: decodes requests and holds row entry zero, length and overflow.
module ted_head #(
	parameter int MAX_REF_LEN = ted_pkg::MAX_REF_LEN_DEF,
	localparam int IW = $clog2(MAX_REF_LEN + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic [ted_pkg::REQ_W-1:0] req_type,
	input  logic [ted_pkg::TOKEN_W-1:0] token,
	input  logic first_of_ref,
	output ted_pkg::wave_t wave_o,
	output logic [IW-1:0] idx_o
);

	logic [ted_pkg::DIST_W-1:0] d0_q, d0_d, d0_inc;
	logic [IW-1:0] len_q, len_d, base_len;
	logic ovf_q, ovf_d, base_ovf;

	always_comb begin
		d0_inc = ted_pkg::sat_inc(d0_q);
		base_len = first_of_ref ? '0 : len_q;
		base_ovf = first_of_ref ? 1'b0 : ovf_q;
		wave_o.op = ted_pkg::OP_NOP;
		wave_o.token = token;
		wave_o.left = d0_inc;
		wave_o.diag = d0_q;
		wave_o.result = d0_q;
		wave_o.ovf = ovf_q;
		idx_o = len_q;
		d0_d = d0_q;
		len_d = len_q;
		ovf_d = ovf_q;
		if (accept) begin
			unique case (req_type)
				ted_pkg::REQ_APPEND: begin
					wave_o.op = ted_pkg::OP_APPEND;
					d0_d = '0;
					if (base_len < IW'(MAX_REF_LEN)) begin
						idx_o = base_len;
						len_d = base_len + IW'(1);
						ovf_d = base_ovf;
					end else begin
						// No cell matches this index, so the token is dropped.
						idx_o = IW'(MAX_REF_LEN);
						len_d = base_len;
						ovf_d = 1'b1;
					end
				end
				ted_pkg::REQ_HYP: begin
					wave_o.op = ted_pkg::OP_HYP;
					d0_d = d0_inc;
				end
				ted_pkg::REQ_END: begin
					wave_o.op = ted_pkg::OP_END;
					d0_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d0_q <= '0;
			len_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			d0_q <= d0_d;
			len_q <= len_d;
			ovf_q <= ovf_d;
		end
	end

endmodule

>>> hdl/ted_cell.sv
// One cell of the chain: holds one reference token and one row entry.
module ted_cell #(
	parameter int MAX_REF_LEN = ted_pkg::MAX_REF_LEN_DEF,
	parameter int CELL_IDX = 1,
	localparam int IW = $clog2(MAX_REF_LEN + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  ted_pkg::wave_t wave_i,
	input  logic [IW-1:0] idx_i,
	output ted_pkg::wave_t wave_o,
	output logic [IW-1:0] idx_o
);

	localparam logic [ted_pkg::DIST_W-1:0] CELL_INIT = ted_pkg::DIST_W'(CELL_IDX);

	logic [ted_pkg::DIST_W-1:0] d_q, d_d;
	logic [ted_pkg::TOKEN_W-1:0] r_q;
	ted_pkg::wave_t wave_q, wave_d;
	logic [IW-1:0] idx_q;
	logic [ted_pkg::DIST_W-1:0] c_up, c_left, c_diag, best;
	logic app_hit, end_hit;

	always_comb begin
		c_up = ted_pkg::sat_inc(d_q);
		c_left = ted_pkg::sat_inc(wave_i.left);
		c_diag = (r_q == wave_i.token) ? wave_i.diag : ted_pkg::sat_inc(wave_i.diag);
		best = c_up;
		if (c_left < best) best = c_left;
		if (c_diag < best) best = c_diag;
		app_hit = (idx_i == IW'(CELL_IDX - 1));
		end_hit = (idx_i == IW'(CELL_IDX));
		wave_d = wave_i;
		d_d = d_q;
		case (wave_i.op)
			ted_pkg::OP_APPEND: begin
				d_d = CELL_INIT;
			end
			ted_pkg::OP_HYP: begin
				d_d = best;
				wave_d.left = best;
				wave_d.diag = d_q;
			end
			ted_pkg::OP_END: begin
				d_d = CELL_INIT;
				if (end_hit) wave_d.result = d_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= CELL_INIT;
			wave_q <= '0;
			idx_q <= '0;
		end else if (en) begin
			d_q <= d_d;
			wave_q <= wave_d;
			idx_q <= idx_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en && wave_i.op == ted_pkg::OP_APPEND && app_hit) r_q <= wave_i.token;
	end

	assign wave_o = wave_q;
	assign idx_o = idx_q;

endmodule

>>> hdl/token_edit_distance.sv
// Top level of the token edit distance block: head, cell chain and result register.
//
// Requests arrive on req (valid/ready). A request of type append stores a
// reference token, type hypothesis advances the distance row by one token and
// type end emits one result on res (distance and the overflow flag), then
// starts a fresh row. Requests of type three are accepted and do nothing.
// Every request enters the head and travels down a chain of MAX_REF_LEN
// cells, one cell per cycle while the chain advances, as a diagonal wavefront;
// cell j holds reference token j and row entry j. Because requests keep their
// order in the chain, a new request of any type can be accepted on each advance.
// The result of an end request is registered in every cell of the chain and
// then in the result register before it is valid on res.
// Throughput: one request per cycle while the result register is free.
// When the receiver stalls with a result waiting, the whole chain holds and
// req.ready drops until that result is taken.
// Reset empties the reference, clears the overflow flag, sets row entry j to
// j in every cell and empties the result register; there is no clearing pass.
module token_edit_distance #(
	parameter int MAX_REF_LEN = ted_pkg::MAX_REF_LEN_DEF,
	localparam int IW = $clog2(MAX_REF_LEN + 1)
) (
	input logic clk,
	input logic arst_n,
	ted_req_if.sink req,
	ted_res_if.source res
);

	// The chain advances whenever the result register is empty or being read.
	logic advance;
	logic accept;

	ted_pkg::wave_t wave [0:MAX_REF_LEN];
	logic [IW-1:0] idx [0:MAX_REF_LEN];

	logic out_valid_q;
	logic [ted_pkg::DIST_W-1:0] dist_q;
	logic ovf_q;

	assign advance = !out_valid_q || res.ready;
	assign accept = req.valid && advance;
	assign req.ready = advance;

	// The head decodes the request and supplies row entry zero to cell one.
	ted_head #(
		.MAX_REF_LEN(MAX_REF_LEN)
	) u_head (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.req_type(req.req_type),
		.token(req.token),
		.first_of_ref(req.first_of_ref),
		.wave_o(wave[0]),
		.idx_o(idx[0])
	);

	// Each cell takes the wavefront from its left neighbor and hands it on.
	for (genvar j = 1; j <= MAX_REF_LEN; j++) begin : g_cell
		ted_cell #(
			.MAX_REF_LEN(MAX_REF_LEN),
			.CELL_IDX(j)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(advance),
			.wave_i(wave[j-1]),
			.idx_i(idx[j-1]),
			.wave_o(wave[j]),
			.idx_o(idx[j])
		);
	end

	// An end request leaving the last cell carries the distance it picked up
	// at the cell that matched the reference length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= (wave[MAX_REF_LEN].op == ted_pkg::OP_END);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wave[MAX_REF_LEN].op == ted_pkg::OP_END) begin
			dist_q <= wave[MAX_REF_LEN].result;
			ovf_q <= wave[MAX_REF_LEN].ovf;
		end
	end

	assign res.valid = out_valid_q;
	assign res.distance = dist_q;
	assign res.ref_overflow = ovf_q;

endmodule

>>> hdl/ted_checker.sv
// Port-level checker for the token edit distance block, bound to its top level.
`include "assert_macros.svh"

module ted_checker (
	input logic clk,
	input logic arst_n,
	input logic req_ready,
	input logic res_valid,
	input logic res_ready,
	input logic [ted_pkg::DIST_W-1:0] res_distance,
	input logic res_ref_overflow
);

	logic stalled;

	assign stalled = res_valid && !res_ready;

	// The block takes requests whenever no result is waiting.
	`ASSERT_IMPLY(a_ready_when_free, clk, arst_n, !res_valid, req_ready, "ready low while free")
	// A stalled result holds the whole chain.
	`ASSERT_IMPLY(a_stall_holds_chain, clk, arst_n, stalled, !req_ready, "request taken in stall")
	`ASSERT_NEXT(a_valid_holds, clk, arst_n, stalled, res_valid, "result withdrawn while stalled")
	`ASSERT_NEXT(a_result_stable, clk, arst_n, stalled, $stable({res_distance, res_ref_overflow}), "result changed")

endmodule

bind token_edit_distance ted_checker u_ted_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_ready(req.ready),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_distance(res.distance),
	.res_ref_overflow(res.ref_overflow)
);
